// ----- hw/rtl/ctsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types, codes and helpers for the clock time set controller.
// ----------------------------------------------------------------------------
package ctsc_pkg;

    // button event codes
    typedef enum logic [1:0] {
        OP_LOG = 2'd0,
        OP_DEC = 2'd1,
        OP_SET = 2'd2,
        OP_INC = 2'd3
    } op_t;

    // mode codes as seen on the result word
    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_LOG  = 2'd1;
    localparam logic [1:0] MODE_CODE_SET  = 2'd2;

    // field codes
    localparam logic [2:0] FIELD_YEAR   = 3'd0;
    localparam logic [2:0] FIELD_MONTH  = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_HOUR   = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;
    localparam logic [2:0] FIELD_SECOND = 3'd5;

    // field limits and cursor layout of "YYYY/MM/DD HH:MM:SS"
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [13:0] YEAR_RESET  = 14'd2025;
    localparam logic [3:0]  MONTH_MAX   = 4'd12;
    localparam logic [4:0]  HOUR_MAX    = 5'd23;
    localparam logic [5:0]  MINSEC_MAX  = 6'd59;
    localparam logic [4:0]  LAST_POS    = 5'd18;
    localparam logic [4:0]  FEB_DAYS    = 5'd28;

    typedef struct packed {
        op_t         opcode;
        logic [13:0] now_year;
        logic [3:0]  now_month;
        logic [4:0]  now_day;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [5:0]  now_second;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  mode_out;
        logic [4:0]  cursor_pos;
        logic [2:0]  field_sel;
        logic [13:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
        logic        commit;
        logic        log_request;
        logic        year_limited;
    } out_word_t;

    // days in a month, february fixed at 28
    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                        len = FEB_DAYS;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

    // separator characters between the fields
    function automatic logic is_separator(input logic [4:0] p);
        return (p == 5'd4) || (p == 5'd7) || (p == 5'd10) ||
               (p == 5'd13) || (p == 5'd16);
    endfunction

    // field under a cursor position
    function automatic logic [2:0] field_of(input logic [4:0] p);
        logic [2:0] f;
        priority if (p <= 5'd3)                  f = FIELD_YEAR;
        else if (p >= 5'd5  && p <= 5'd6)        f = FIELD_MONTH;
        else if (p >= 5'd8  && p <= 5'd9)        f = FIELD_DAY;
        else if (p >= 5'd11 && p <= 5'd12)       f = FIELD_HOUR;
        else if (p >= 5'd14 && p <= 5'd15)       f = FIELD_MINUTE;
        else if (p >= 5'd17 && p <= 5'd18)       f = FIELD_SECOND;
        else                                     f = FIELD_YEAR;
        return f;
    endfunction

endpackage

// ----- hw/rtl/ctsc_if.sv -----
// ----------------------------------------------------------------------------
// ctsc channel interfaces
// Valid/ready channels carrying button words in and result words out.
// ----------------------------------------------------------------------------
interface ctsc_in_if;
    logic                valid;
    logic                ready;
    ctsc_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctsc_out_if;
    logic                valid;
    logic                ready;
    ctsc_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/clock_time_set_controller.sv -----
// ----------------------------------------------------------------------------
// clock_time_set_controller
// Button driven time setting for a digital clock: modes, cursor and fields.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one debounced button word with the current clock time; res
//   returns one result word for every accepted button word, in order.
//   A word is taken on a rising edge where valid and ready are both high.
//   The mode and edit registers and the result register are all loaded at the
//   edge that takes the button word, and the result shows on res the cycle
//   after.
//   Throughput is one word per cycle while res is not stalled; the only
//   register between the two channels is the result register, so cmd.ready is
//   high whenever that register is empty or is being emptied at the same edge.
//   When the receiver stalls the result word holds and cmd.ready drops until
//   it is taken; no word is dropped or repeated.
//   Reset puts the block in idle with the cursor at 0, the edit time at
//   2025/01/01 00:00:00 and the result register empty.
// ----------------------------------------------------------------------------
module clock_time_set_controller (
    input  logic       clk,
    input  logic       rst_n,
    ctsc_in_if.sink    cmd,
    ctsc_out_if.source res
);
    import ctsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOG  = 3'b010,
        ST_SET  = 3'b100
    } mode_t;

    mode_t       mode_reg,   mode_next;
    logic [4:0]  pos_reg,    pos_next;
    logic [13:0] year_reg,   year_next;
    logic [3:0]  month_reg,  month_next;
    logic [4:0]  day_reg,    day_next;
    logic [4:0]  hour_reg,   hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;

    logic        commit_next;
    logic        log_next;
    logic        lim_next;

    out_word_t   res_reg,    res_next;
    logic        res_valid_reg;
    logic        take;

    // generic wrap step on narrow values
    function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic up,
                                             input logic [5:0] lo,
                                             input logic [5:0] hi);
        logic [5:0] r;
        if (up)
            r = (v >= hi) ? lo : v + 6'd1;
        else
            r = (v <= lo) ? hi : v - 6'd1;
        return r;
    endfunction

    // button handling and field update
    always_comb
    begin
        logic       up;
        logic [3:0] m_clamp;
        logic [4:0] m_len;
        logic [4:0] p1;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        commit_next = 1'b0;
        log_next    = 1'b0;
        lim_next    = 1'b0;

        up      = (cmd.data.opcode == OP_INC);
        m_clamp = (cmd.data.now_month == 4'd0) ? 4'd1 :
                  (cmd.data.now_month > MONTH_MAX) ? MONTH_MAX : cmd.data.now_month;
        m_len   = month_length(m_clamp);
        p1      = pos_reg + 5'd1;

        unique case (cmd.data.opcode)
            OP_LOG:
            begin
                if (mode_reg != ST_LOG && mode_reg != ST_SET)
                begin
                    log_next  = 1'b1;
                    mode_next = ST_IDLE;
                end
            end
            OP_DEC, OP_INC:
            begin
                if (mode_reg == ST_SET)
                begin
                    // adjust the field under the cursor
                    unique case (field_of(pos_reg))
                        FIELD_MONTH:
                        begin
                            month_next = 4'(wrap_step(6'(month_reg), up, 6'd1,
                                                      6'(MONTH_MAX)));
                            if (day_reg > month_length(month_next))
                                day_next = month_length(month_next);
                        end
                        FIELD_DAY:
                            day_next = 5'(wrap_step(6'(day_reg), up, 6'd1,
                                                    6'(month_length(month_reg))));
                        FIELD_HOUR:
                            hour_next = 5'(wrap_step(6'(hour_reg), up, 6'd0,
                                                     6'(HOUR_MAX)));
                        FIELD_MINUTE:
                            minute_next = wrap_step(minute_reg, up, 6'd0, MINSEC_MAX);
                        FIELD_SECOND:
                            second_next = wrap_step(second_reg, up, 6'd0, MINSEC_MAX);
                        default:
                        begin
                            // year saturates at both ends
                            if (up)
                            begin
                                if (year_reg >= YEAR_MAX)
                                begin
                                    year_next = YEAR_MAX;
                                    lim_next  = 1'b1;
                                end
                                else
                                    year_next = year_reg + 14'd1;
                            end
                            else
                            begin
                                if (year_reg == 14'd0)
                                    lim_next = 1'b1;
                                else
                                    year_next = year_reg - 14'd1;
                            end
                        end
                    endcase
                end
                else if (!up)
                begin
                    // replay toggles log view
                    mode_next = (mode_reg == ST_LOG) ? ST_IDLE : ST_LOG;
                end
            end
            default:
            begin
                if (mode_reg == ST_SET)
                begin
                    if (pos_reg == LAST_POS)
                    begin
                        commit_next = 1'b1;
                        mode_next   = ST_IDLE;
                    end
                    else
                        pos_next = is_separator(p1) ? p1 + 5'd1 : p1;
                end
                else if (mode_reg != ST_LOG)
                begin
                    // capture the current time, clamped into range
                    mode_next   = ST_SET;
                    pos_next    = 5'd0;
                    year_next   = (cmd.data.now_year > YEAR_MAX) ? YEAR_MAX
                                                                 : cmd.data.now_year;
                    month_next  = m_clamp;
                    day_next    = (cmd.data.now_day == 5'd0) ? 5'd1 :
                                  (cmd.data.now_day > m_len) ? m_len : cmd.data.now_day;
                    hour_next   = (cmd.data.now_hour > HOUR_MAX) ? HOUR_MAX
                                                                 : cmd.data.now_hour;
                    minute_next = (cmd.data.now_minute > MINSEC_MAX) ? MINSEC_MAX
                                                                     : cmd.data.now_minute;
                    second_next = (cmd.data.now_second > MINSEC_MAX) ? MINSEC_MAX
                                                                     : cmd.data.now_second;
                end
            end
        endcase
    end

    // result word assembly
    always_comb
    begin
        unique case (mode_next)
            ST_LOG:  res_next.mode_out = MODE_CODE_LOG;
            ST_SET:  res_next.mode_out = MODE_CODE_SET;
            default: res_next.mode_out = MODE_CODE_IDLE;
        endcase
        res_next.cursor_pos   = pos_next;
        res_next.field_sel    = field_of(pos_next);
        res_next.set_year     = year_next;
        res_next.set_month    = month_next;
        res_next.set_day      = day_next;
        res_next.set_hour     = hour_next;
        res_next.set_minute   = minute_next;
        res_next.set_second   = second_next;
        res_next.commit       = commit_next;
        res_next.log_request  = log_next;
        res_next.year_limited = lim_next;
    end

    // handshake
    assign cmd.ready = !res_valid_reg || res.ready;
    assign take      = cmd.valid && cmd.ready;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    // mode and edit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ST_IDLE;
            pos_reg    <= 5'd0;
            year_reg   <= YEAR_RESET;
            month_reg  <= 4'd1;
            day_reg    <= 5'd1;
            hour_reg   <= 5'd0;
            minute_reg <= 6'd0;
            second_reg <= 6'd0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (take)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

endmodule

// ----- hw/rtl/ctsc_check.sv -----
// ----------------------------------------------------------------------------
// ctsc_check
// Port level checks for the clock time set controller, bound to the top.
// ----------------------------------------------------------------------------
module ctsc_check (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input ctsc_pkg::out_word_t out_data
);
    import ctsc_pkg::*;

    // a result word waits until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // every taken button word gives a result word next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after accepted button word");

    // commit and log request only ever leave the block in idle
    a_flags_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.commit || out_data.log_request) |->
        out_data.mode_out == MODE_CODE_IDLE)
        else $error("commit or log request outside idle");

    // a limited year sits at a bound while in time set
    a_year_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.year_limited |->
        out_data.mode_out == MODE_CODE_SET &&
        (out_data.set_year == 14'd0 || out_data.set_year == YEAR_MAX))
        else $error("year limit flag without saturated year");

    // the cursor never rests on a separator
    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !is_separator(out_data.cursor_pos) &&
        out_data.cursor_pos <= LAST_POS)
        else $error("cursor off a digit");

endmodule

bind clock_time_set_controller ctsc_check u_ctsc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.data)
);
